// File: hw/rtl/hflt_pkg.sv
// Shared types, constants and a decode helper for the hex-float literal parser.
`timescale 1ns / 1ps
`default_nettype none
package hflt_pkg;

  // Default width of the signed exponent counters
  localparam int EXP_CNT_W_DEF = 20;

  // IEEE format constants
  localparam int FRAC_SP = 23;
  localparam int FRAC_DP = 52;
  localparam int BIAS_SP = 127;
  localparam int BIAS_DP = 1023;

  // Exponent value past which the result is surely infinity or zero
  localparam int EXP_STOP_SP = 2 * 128 + 64;
  localparam int EXP_STOP_DP = 2 * 1024 + 64;

  // Scanner phase, one-hot
  typedef enum logic [7:0] {
    PH_START          = 8'b0000_0001,
    PH_AFTER_SIGN     = 8'b0000_0010,
    PH_AFTER_ZERO     = 8'b0000_0100,
    PH_SIG_EMPTY      = 8'b0000_1000,
    PH_SIG            = 8'b0001_0000,
    PH_EXP_START      = 8'b0010_0000,
    PH_EXP_AFTER_SIGN = 8'b0100_0000,
    PH_EXP_DIGITS     = 8'b1000_0000
  } phase_t;

  // Flags of a finished literal handed to the rounding pipeline
  typedef struct packed {
    logic negative;
    logic sticky;
    logic pow_neg;
    logic ok;
    logic dbl;
  } snap_flags_t;

  // Decode a hex digit: bit 4 is valid, bits 3:0 the value
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0;
    if (c >= "0" && c <= "9") r = {1'b1, 4'(c - "0")};
    else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - "a" + 8'd10)};
    else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - "A" + 8'd10)};
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/hflt_intf.sv
// Channel interfaces: character input, result output and format register write.
`timescale 1ns / 1ps
`default_nettype none
interface hflt_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last_char;
  modport source (output valid, text_char, last_char, input ready);
  modport sink   (input valid, text_char, last_char, output ready);
endinterface

interface hflt_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] float_bits;
  logic        parse_error;
  modport source (output valid, float_bits, parse_error, input ready);
  modport sink   (input valid, float_bits, parse_error, output ready);
endinterface

interface hflt_cfg_if;
  logic valid;
  logic ready;
  logic double_precision;
  modport source (output valid, double_precision, input ready);
  modport sink   (input valid, double_precision, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/hex_float_literal_to_ieee_bits.sv
// Top level of the hex-float literal to IEEE bit pattern converter.
`timescale 1ns / 1ps
`default_nettype none
// Takes a literal such as -0x1.8p+3 one character per word and, for the word
// marked last, returns one IEEE single or double bit pattern (single in the
// low 32 bits) with parse_error set for malformed text or overflow. One
// character is accepted every cycle unless the stalled pipeline is full; the
// scanner updates its state in the cycle a word is taken, and a finished
// literal then passes a five-register rounding pipeline, with new literals
// streaming in behind it. A stalled output fills the pipeline and then holds
// off characters until the output drains. The format register is sampled per
// character and is always ready; write it only while idle.
module hex_float_literal_to_ieee_bits #(
  parameter int EXP_COUNTER_WIDTH = hflt_pkg::EXP_CNT_W_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  hflt_char_if.sink    in_ch,
  hflt_res_if.source   out_ch,
  hflt_cfg_if.sink     cfg_ch
);
  import hflt_pkg::*;

  localparam int W = EXP_COUNTER_WIDTH;

  logic                in_fire;
  logic                snap_v, snap_ready;
  logic [63:0]         snap_acc;
  logic signed [W-1:0] snap_dot, snap_pv;
  snap_flags_t         snap_flags;

  // Accept characters while the pipeline can take a finished literal
  assign in_ch.ready  = snap_ready;
  assign in_fire      = in_ch.valid && snap_ready;
  assign cfg_ch.ready = 1'b1;

  hflt_scan #(.W(W)) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .text_char  (in_ch.text_char),
    .last_char  (in_ch.last_char),
    .cfg_fire   (cfg_ch.valid),
    .cfg_dbl    (cfg_ch.double_precision),
    .snap_v     (snap_v),
    .snap_acc   (snap_acc),
    .snap_dot   (snap_dot),
    .snap_pv    (snap_pv),
    .snap_flags (snap_flags)
  );

  hflt_round #(.W(W)) u_round (
    .clk        (clk),
    .rst_n      (rst_n),
    .snap_v     (snap_v),
    .snap_acc   (snap_acc),
    .snap_dot   (snap_dot),
    .snap_pv    (snap_pv),
    .snap_flags (snap_flags),
    .snap_ready (snap_ready),
    .res_valid  (out_ch.valid),
    .res_ready  (out_ch.ready),
    .res_bits   (out_ch.float_bits),
    .res_err    (out_ch.parse_error)
  );

endmodule
`default_nettype wire

// File: hw/rtl/hflt_scan.sv
// Character scanner: grammar phase, significand accumulator and exponent counters.
`timescale 1ns / 1ps
`default_nettype none
module hflt_scan #(
  parameter int W = hflt_pkg::EXP_CNT_W_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_fire,
  input  wire logic [7:0]           text_char,
  input  wire logic                 last_char,
  input  wire logic                 cfg_fire,
  input  wire logic                 cfg_dbl,
  output logic                      snap_v,
  output logic [63:0]               snap_acc,
  output logic signed [W-1:0]       snap_dot,
  output logic signed [W-1:0]       snap_pv,
  output hflt_pkg::snap_flags_t     snap_flags
);
  import hflt_pkg::*;

  localparam logic signed [W+5:0] CMAX_X = (W+6)'((64'sd1 <<< (W-1)) - 64'sd1);
  localparam logic signed [W+5:0] CMIN_X = -CMAX_X - (W+6)'(1);

  // Clamp a widened count into the counter range
  function automatic logic signed [W-1:0] sat_cnt(input logic signed [W+5:0] v);
    logic signed [W-1:0] r;
    r = v[W-1:0];
    if (v > CMAX_X) r = CMAX_X[W-1:0];
    if (v < CMIN_X) r = CMIN_X[W-1:0];
    return r;
  endfunction

  phase_t              phase_r, phase_nxt;
  logic                neg_r, neg_nxt;
  logic [63:0]         acc_r, acc_nxt;
  logic signed [W-1:0] dot_r, dot_nxt;
  logic                pt_r, pt_nxt;
  logic                sticky_r, sticky_nxt;
  logic signed [W-1:0] pv_r, pv_nxt;
  logic                pneg_r, pneg_nxt;
  logic signed [W-1:0] pbias_r, pbias_nxt;
  logic                pstop_r, pstop_nxt;
  logic                err_r, err_nxt;
  logic                dbl_r;

  logic [4:0]          hx;
  logic                is_dec;
  logic [3:0]          dg;
  logic                do_exp;
  logic                acc_room;
  logic signed [W+5:0] pvx;
  logic signed [W:0]   pv_sum;
  logic signed [W:0]   stop_lim;

  // Format register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbl_r <= 1'b0;
    end else if (cfg_fire) begin
      dbl_r <= cfg_dbl;
    end
  end

  // Next parse state for one character
  always_comb begin
    phase_nxt  = phase_r;
    neg_nxt    = neg_r;
    acc_nxt    = acc_r;
    dot_nxt    = dot_r;
    pt_nxt     = pt_r;
    sticky_nxt = sticky_r;
    pv_nxt     = pv_r;
    pneg_nxt   = pneg_r;
    pbias_nxt  = pbias_r;
    pstop_nxt  = pstop_r;
    err_nxt    = err_r;
    do_exp     = 1'b0;
    hx         = hex_decode(text_char);
    is_dec     = text_char inside {["0":"9"]};
    dg         = text_char[3:0];
    acc_room   = dbl_r ? (acc_r[63:53] == '0) : (acc_r[63:24] == '0);
    pvx        = (W+6)'(pv_r);
    pv_sum     = '0;
    stop_lim   = dbl_r ? (W+1)'(EXP_STOP_DP) : (W+1)'(EXP_STOP_SP);
    if (!err_r) begin
      case (phase_r)
        PH_START: begin
          if (text_char == "-") begin
            neg_nxt   = 1'b1;
            phase_nxt = PH_AFTER_SIGN;
          end else if (text_char == "+") begin
            phase_nxt = PH_AFTER_SIGN;
          end else if (text_char == "0") begin
            phase_nxt = PH_AFTER_ZERO;
          end else begin
            err_nxt = 1'b1;
          end
        end
        PH_AFTER_SIGN: begin
          if (text_char == "0") phase_nxt = PH_AFTER_ZERO;
          else err_nxt = 1'b1;
        end
        PH_AFTER_ZERO: begin
          if (text_char == "x") phase_nxt = PH_SIG_EMPTY;
          else err_nxt = 1'b1;
        end
        PH_SIG_EMPTY, PH_SIG: begin
          if (text_char != "_") begin
            if (text_char == ".") begin
              if (pt_r) err_nxt = 1'b1;
              else pt_nxt = 1'b1;
            end else if (hx[4]) begin
              // Accumulate while there is room, else only track sticky and scale
              if (acc_room) begin
                acc_nxt = {acc_r[59:0], hx[3:0]};
                if (pt_r) dot_nxt = sat_cnt((W+6)'(dot_r) - (W+6)'(4));
              end else begin
                if (hx[3:0] != 4'd0) sticky_nxt = 1'b1;
                if (!pt_r) dot_nxt = sat_cnt((W+6)'(dot_r) + (W+6)'(4));
              end
              phase_nxt = PH_SIG;
            end else if ((text_char == "p" || text_char == "P") && phase_r == PH_SIG) begin
              pbias_nxt = dot_r;
              phase_nxt = PH_EXP_START;
            end else begin
              err_nxt = 1'b1;
            end
          end
        end
        PH_EXP_START: begin
          if (text_char == "-") begin
            pneg_nxt  = 1'b1;
            pbias_nxt = sat_cnt(-((W+6)'(dot_r)));
            phase_nxt = PH_EXP_AFTER_SIGN;
          end else if (text_char == "+") begin
            phase_nxt = PH_EXP_AFTER_SIGN;
          end else begin
            do_exp = 1'b1;
          end
        end
        PH_EXP_AFTER_SIGN, PH_EXP_DIGITS: do_exp = 1'b1;
        default: err_nxt = 1'b1;
      endcase
      // Exponent digits and separators
      if (do_exp) begin
        if (text_char == "_") begin
          if (phase_r == PH_EXP_START) phase_nxt = PH_EXP_AFTER_SIGN;
        end else if (is_dec) begin
          if (!pstop_r) begin
            pv_nxt = sat_cnt((pvx <<< 3) + (pvx <<< 1) + (W+6)'($signed({1'b0, dg})));
            pv_sum = (W+1)'(pv_nxt) + (W+1)'(pbias_r);
            if (pv_sum >= stop_lim) pstop_nxt = 1'b1;
          end
          phase_nxt = PH_EXP_DIGITS;
        end else begin
          err_nxt = 1'b1;
        end
      end
    end
  end

  // Hand the finished literal to the rounding pipeline
  always_comb begin
    snap_v              = in_fire && last_char;
    snap_acc            = acc_nxt;
    snap_dot            = dot_nxt;
    snap_pv             = pv_nxt;
    snap_flags.negative = neg_nxt;
    snap_flags.sticky   = sticky_nxt;
    snap_flags.pow_neg  = pneg_nxt;
    snap_flags.ok       = !err_nxt && (phase_nxt == PH_SIG || phase_nxt == PH_EXP_DIGITS);
    snap_flags.dbl      = dbl_r;
  end

  // Parse state: advance per word, clear after the last one
  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && last_char)) begin
      phase_r  <= PH_START;
      neg_r    <= 1'b0;
      acc_r    <= '0;
      dot_r    <= '0;
      pt_r     <= 1'b0;
      sticky_r <= 1'b0;
      pv_r     <= '0;
      pneg_r   <= 1'b0;
      pbias_r  <= '0;
      pstop_r  <= 1'b0;
      err_r    <= 1'b0;
    end else if (in_fire) begin
      phase_r  <= phase_nxt;
      neg_r    <= neg_nxt;
      acc_r    <= acc_nxt;
      dot_r    <= dot_nxt;
      pt_r     <= pt_nxt;
      sticky_r <= sticky_nxt;
      pv_r     <= pv_nxt;
      pneg_r   <= pneg_nxt;
      pbias_r  <= pbias_nxt;
      pstop_r  <= pstop_nxt;
      err_r    <= err_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/hflt_round.sv
// Rounding pipeline: normalize, round to nearest even and pack IEEE bits.
`timescale 1ns / 1ps
`default_nettype none
module hflt_round #(
  parameter int W = hflt_pkg::EXP_CNT_W_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 snap_v,
  input  wire logic [63:0]          snap_acc,
  input  wire logic signed [W-1:0]  snap_dot,
  input  wire logic signed [W-1:0]  snap_pv,
  input  wire hflt_pkg::snap_flags_t snap_flags,
  output logic                      snap_ready,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output logic [63:0]               res_bits,
  output logic                      res_err
);
  import hflt_pkg::*;

  localparam int EW = W + 3;

  // Bit length of a 64-bit word by a six-step halving search
  function automatic logic [6:0] bit_len(input logic [63:0] v);
    logic [63:0] x;
    logic [6:0]  z;
    x = v;
    z = 7'd0;
    if (x[63:32] == '0) begin z = z + 7'd32; x = x << 32; end
    if (x[63:48] == '0) begin z = z + 7'd16; x = x << 16; end
    if (x[63:56] == '0) begin z = z + 7'd8;  x = x << 8;  end
    if (x[63:60] == '0) begin z = z + 7'd4;  x = x << 4;  end
    if (x[63:62] == '0) begin z = z + 7'd2;  x = x << 2;  end
    if (x[63] == 1'b0)  begin z = z + 7'd1; end
    return (v == '0) ? 7'd0 : 7'd64 - z;
  endfunction

  // Stage valids and load enables
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  logic ld1, ld2, ld3, ld4, ld5;

  assign ld5        = !s5_v_r || res_ready;
  assign ld4        = !s4_v_r || ld5;
  assign ld3        = !s3_v_r || ld4;
  assign ld2        = !s2_v_r || ld3;
  assign ld1        = !s1_v_r || ld2;
  assign snap_ready = ld1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      if (ld1) s1_v_r <= snap_v;
      if (ld2) s2_v_r <= s1_v_r;
      if (ld3) s3_v_r <= s2_v_r;
      if (ld4) s4_v_r <= s3_v_r;
      if (ld5) s5_v_r <= s4_v_r;
    end
  end

  // Stage 1: capture the literal
  logic [63:0]         s1_acc_r;
  logic signed [W-1:0] s1_dot_r, s1_pv_r;
  snap_flags_t         s1_f_r;

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_acc_r <= snap_acc;
      s1_dot_r <= snap_dot;
      s1_pv_r  <= snap_pv;
      s1_f_r   <= snap_flags;
    end
  end

  // Stage 2: bit length and unbiased exponent
  logic [6:0]           nb_nxt;
  logic signed [EW-1:0] e_nxt, pvx;
  logic [63:0]          s2_acc_r;
  logic [6:0]           s2_nb_r;
  logic signed [EW-1:0] s2_e_r;
  snap_flags_t          s2_f_r;

  always_comb begin
    nb_nxt = bit_len(s1_acc_r);
    pvx    = EW'(s1_pv_r);
    e_nxt  = (s1_f_r.pow_neg ? -pvx : pvx) + EW'(s1_dot_r)
             + EW'($signed({1'b0, nb_nxt})) - EW'(1);
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_acc_r <= s1_acc_r;
      s2_nb_r  <= nb_nxt;
      s2_e_r   <= e_nxt;
      s2_f_r   <= s1_f_r;
    end
  end

  // Stage 3: normal or subnormal, and the alignment shift
  logic signed [EW-1:0] bias3, frac3;
  logic signed [EW:0]   sh;
  logic                 norm_nxt;
  logic [63:0]          s3_acc_r;
  logic signed [EW-1:0] s3_e_r;
  logic                 s3_norm_r, s3_big_r, s3_pos_r, s3_zero_r;
  logic [5:0]           s3_amt_r;
  snap_flags_t          s3_f_r;

  always_comb begin
    bias3    = s2_f_r.dbl ? EW'(BIAS_DP) : EW'(BIAS_SP);
    frac3    = s2_f_r.dbl ? EW'(FRAC_DP) : EW'(FRAC_SP);
    norm_nxt = s2_e_r > -bias3;
    if (norm_nxt) begin
      sh = (EW+1)'($signed({1'b0, s2_nb_r})) - (EW+1)'(frac3) - (EW+1)'(1);
    end else begin
      sh = -(EW+1)'(bias3) - (EW+1)'(frac3) - (EW+1)'(s2_e_r)
           + (EW+1)'($signed({1'b0, s2_nb_r}));
    end
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      s3_acc_r  <= s2_acc_r;
      s3_e_r    <= s2_e_r;
      s3_norm_r <= norm_nxt;
      s3_big_r  <= sh > (EW+1)'(63);
      s3_pos_r  <= sh > (EW+1)'(0);
      s3_amt_r  <= (sh > (EW+1)'(0)) ? sh[5:0] : 6'(-sh);
      s3_zero_r <= (s2_nb_r == 7'd0);
      s3_f_r    <= s2_f_r;
    end
  end

  // Stage 4: align and find round and sticky bits
  logic [63:0]          q4;
  logic                 rb4, below4;
  logic [63:0]          s4_q_r;
  logic                 s4_inc_r, s4_norm_r, s4_zero_r;
  logic signed [EW-1:0] s4_e_r;
  snap_flags_t          s4_f_r;

  always_comb begin
    q4     = '0;
    rb4    = 1'b0;
    below4 = 1'b0;
    if (s3_big_r) begin
      q4 = '0;
    end else if (s3_pos_r) begin
      q4     = s3_acc_r >> s3_amt_r;
      rb4    = s3_acc_r[s3_amt_r - 6'd1];
      below4 = (s3_acc_r & ~({64{1'b1}} << (s3_amt_r - 6'd1))) != '0;
    end else begin
      q4 = s3_acc_r << s3_amt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      s4_q_r    <= q4;
      s4_inc_r  <= rb4 && (below4 || s3_f_r.sticky || q4[0]);
      s4_norm_r <= s3_norm_r;
      s4_zero_r <= s3_zero_r;
      s4_e_r    <= s3_e_r;
      s4_f_r    <= s3_f_r;
    end
  end

  // Stage 5: round, renormalize, check overflow and pack
  logic [63:0]          q5, qn;
  logic signed [EW-1:0] e5, bias5;
  logic [10:0]          expf;
  logic [63:0]          sgn;
  logic [63:0]          bits5;
  logic                 err5;
  logic                 s5_dbl_r;

  always_comb begin
    q5    = s4_q_r + 64'(s4_inc_r);
    bias5 = s4_f_r.dbl ? EW'(BIAS_DP) : EW'(BIAS_SP);
    qn    = q5;
    e5    = s4_e_r;
    if (s4_f_r.dbl ? q5[53] : q5[24]) begin
      qn = q5 >> 1;
      e5 = s4_e_r + EW'(1);
    end
    expf  = 11'(e5 + bias5);
    sgn   = s4_f_r.dbl ? {s4_f_r.negative, 63'd0} : {32'd0, s4_f_r.negative, 31'd0};
    err5  = 1'b0;
    bits5 = sgn;
    if (!s4_f_r.ok) begin
      err5  = 1'b1;
      bits5 = '0;
    end else if (s4_zero_r) begin
      bits5 = sgn;
    end else if (!s4_norm_r) begin
      bits5 = s4_f_r.dbl ? {s4_f_r.negative, q5[62:0]} : {32'd0, s4_f_r.negative, q5[30:0]};
    end else if (e5 >= bias5 + EW'(1)) begin
      err5  = 1'b1;
      bits5 = '0;
    end else begin
      bits5 = s4_f_r.dbl ? {s4_f_r.negative, expf, qn[51:0]}
                         : {32'd0, s4_f_r.negative, expf[7:0], qn[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (ld5) begin
      res_bits <= bits5;
      res_err  <= err5;
      s5_dbl_r <= s4_f_r.dbl;
    end
  end

  assign res_valid = s5_v_r;

  // An error result carries no bits
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_err |-> res_bits == '0)
    else $error("error result with nonzero bits");

  // Single format leaves the upper half clear
  a_single_hi: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !s5_dbl_r |-> res_bits[63:32] == '0)
    else $error("single result with upper bits set");

  // A stalled result stays in the output register
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res_bits) && $stable(res_err))
    else $error("stalled result lost or changed");

  // A waiting stage 4 word is never dropped while the output stalls
  a_s4_keep: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r && !ld5 |=> s4_v_r)
    else $error("stage 4 word dropped under stall");

endmodule
`default_nettype wire

// File: bench/tb_hex_float_literal_to_ieee_bits.sv
// Self-checking testbench for the hex-float literal to IEEE bit pattern converter.
`timescale 1ns / 1ps
module tb_hex_float_literal_to_ieee_bits;
  import hflt_pkg::*;

  localparam longint CNT_MAX = (64'sd1 <<< (EXP_CNT_W_DEF - 1)) - 1;
  localparam longint CNT_MIN = -CNT_MAX - 1;
  localparam int     LATENCY = 5;

  typedef struct {
    bit [63:0] bits;
    bit        err;
  } ieee_word_t;

  typedef struct {
    string     text;
    bit        dbl;
    bit        known;
    bit [63:0] bits;
    bit        err;
  } lit_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hflt_char_if in_ch();
  hflt_res_if  out_ch();
  hflt_cfg_if  cfg_ch();

  hex_float_literal_to_ieee_bits dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always #1 clk = ~clk;

  // Scanner shadow state
  bit         fmt_dbl;
  phase_t     scan_phase;
  bit         lit_neg;
  bit [63:0]  sig_acc;
  longint     point_exp;
  bit         point_seen;
  bit         sig_sticky;
  longint     pow_val;
  bit         pow_neg;
  longint     pow_bias;
  bit         pow_stop;
  bit         bad_text;

  ieee_word_t pending_words[$];
  ieee_word_t last_word;
  bit         failed = 1'b0;
  int         rows_sent = 0;
  int         sent_chars = 0;
  int         rx_cycle = 0;

  function automatic longint clamp_cnt(longint v);
    if (v > CNT_MAX) return CNT_MAX;
    if (v < CNT_MIN) return CNT_MIN;
    return v;
  endfunction

  function automatic int bit_len(bit [63:0] v);
    int n;
    n = 0;
    while (v != 0) begin
      n++;
      v >>= 1;
    end
    return n;
  endfunction

  function automatic int hex_val(bit [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic void clear_scan();
    scan_phase = PH_START;
    lit_neg = 0;
    sig_acc = 0;
    point_exp = 0;
    point_seen = 0;
    sig_sticky = 0;
    pow_val = 0;
    pow_neg = 0;
    pow_bias = 0;
    pow_stop = 0;
    bad_text = 0;
  endfunction

  // Normalize and round the finished literal; return 0 on overflow
  function automatic bit round_to_ieee(output bit [63:0] bits);
    int        frac, nb;
    longint    bias, e, shift;
    bit [63:0] sgn, q, below;
    bit        normal, rb;
    frac = fmt_dbl ? FRAC_DP : FRAC_SP;
    bias = fmt_dbl ? BIAS_DP : BIAS_SP;
    sgn = lit_neg ? (64'd1 << (fmt_dbl ? 63 : 31)) : 64'd0;
    bits = sgn;
    if (sig_acc == 0) return 1;
    nb = bit_len(sig_acc);
    e = (pow_neg ? -pow_val : pow_val) + point_exp + nb - 1;
    normal = e > -bias;
    shift = normal ? nb - (frac + 1) : -bias - frac - e + nb;
    if (shift > 63) begin
      q = 0;
    end else if (shift > 0) begin
      below = sig_acc & ((64'd1 << (shift - 1)) - 1);
      rb = sig_acc[shift - 1];
      q = sig_acc >> shift;
      if (rb && (below != 0 || sig_sticky || q[0])) q++;
    end else begin
      q = sig_acc << (-shift);
    end
    if (!normal) begin
      bits = sgn | q;
      return 1;
    end
    if ((q >> (frac + 1)) != 0) begin
      q >>= 1;
      e++;
    end
    if (e >= bias + 1) begin
      bits = 0;
      return 0;
    end
    bits = sgn | (64'(e + bias) << frac) | (q & ((64'd1 << frac) - 1));
    return 1;
  endfunction

  // Advance the shadow scanner by one accepted word
  function automatic void scan_word(bit [7:0] c, bit last);
    int         d;
    longint     lim;
    ieee_word_t w;
    bit         ok;
    d = hex_val(c);
    if (!bad_text) begin
      case (scan_phase)
        PH_START: begin
          if (c == "-") begin
            lit_neg = 1;
            scan_phase = PH_AFTER_SIGN;
          end else if (c == "+") scan_phase = PH_AFTER_SIGN;
          else if (c == "0") scan_phase = PH_AFTER_ZERO;
          else bad_text = 1;
        end
        PH_AFTER_SIGN: begin
          if (c == "0") scan_phase = PH_AFTER_ZERO;
          else bad_text = 1;
        end
        PH_AFTER_ZERO: begin
          if (c == "x") scan_phase = PH_SIG_EMPTY;
          else bad_text = 1;
        end
        PH_SIG_EMPTY, PH_SIG: begin
          if (c == "_") begin
          end else if (c == ".") begin
            if (point_seen) bad_text = 1;
            else point_seen = 1;
          end else if (d >= 0) begin
            // Keep digits while under precision, else fold into sticky
            if (bit_len(sig_acc) <= (fmt_dbl ? 53 : 24)) begin
              sig_acc = (sig_acc << 4) | 64'(d);
              if (point_seen) point_exp = clamp_cnt(point_exp - 4);
            end else begin
              if (d != 0) sig_sticky = 1;
              if (!point_seen) point_exp = clamp_cnt(point_exp + 4);
            end
            scan_phase = PH_SIG;
          end else if ((c == "p" || c == "P") && scan_phase == PH_SIG) begin
            pow_bias = point_exp;
            scan_phase = PH_EXP_START;
          end else bad_text = 1;
        end
        default: begin
          if (scan_phase == PH_EXP_START && c == "-") begin
            pow_neg = 1;
            pow_bias = clamp_cnt(-point_exp);
            scan_phase = PH_EXP_AFTER_SIGN;
          end else if (scan_phase == PH_EXP_START && c == "+") begin
            scan_phase = PH_EXP_AFTER_SIGN;
          end else if (c == "_") begin
            if (scan_phase == PH_EXP_START) scan_phase = PH_EXP_AFTER_SIGN;
          end else if (c >= "0" && c <= "9") begin
            lim = (fmt_dbl ? 2048 : 256) + 64;
            if (!pow_stop) begin
              pow_val = clamp_cnt(pow_val * 10 + (c - "0"));
              if (pow_val + pow_bias >= lim) pow_stop = 1;
            end
            scan_phase = PH_EXP_DIGITS;
          end else bad_text = 1;
        end
      endcase
    end
    if (!last) return;
    ok = !bad_text && (scan_phase == PH_SIG || scan_phase == PH_EXP_DIGITS);
    w.bits = 0;
    if (ok) ok = round_to_ieee(w.bits);
    if (!ok) w.bits = 0;
    w.err = !ok;
    pending_words.push_back(w);
    last_word = w;
    clear_scan();
  endfunction

  // Send one word; sender bursts with random gaps, except in one of every four 150-character spans
  int burst_left = 0;
  task automatic send_word(bit [7:0] c, bit last);
    in_ch.valid <= 1'b1;
    in_ch.text_char <= c;
    in_ch.last_char <= last;
    do @(posedge clk); while (!in_ch.ready);
    scan_word(c, last);
    sent_chars++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ((sent_chars / 150) % 4 != 1) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_literal(bit [7:0] lit[$]);
    foreach (lit[i]) send_word(lit[i], i == lit.size() - 1);
  endtask

  // Drain the pipeline, then write the format register
  task automatic set_format(bit dbl);
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.double_precision <= dbl;
    do @(posedge clk); while (!cfg_ch.ready);
    fmt_dbl = dbl;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic bit [7:0] pick_hex();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(0, 21)];
  endfunction

  // Build a mostly well-formed literal with random content
  function automatic void make_literal(ref bit [7:0] lit[$]);
    int n_sig, n_exp, dot_at, k;
    lit.delete();
    case ($urandom_range(0, 3))
      0: lit.push_back("-");
      1: lit.push_back("+");
      default: ;
    endcase
    lit.push_back("0");
    lit.push_back("x");
    n_sig = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 8);
    dot_at = ($urandom_range(0, 1) != 0) ? $urandom_range(0, n_sig) : -1;
    for (int i = 0; i <= n_sig; i++) begin
      if (i == dot_at) lit.push_back(".");
      if ($urandom_range(0, 9) == 0) lit.push_back("_");
      if (i < n_sig) lit.push_back(($urandom_range(0, 5) == 0) ? "0" : pick_hex());
    end
    if ($urandom_range(0, 9) < 7) begin
      lit.push_back(($urandom_range(0, 1) != 0) ? "p" : "P");
      case ($urandom_range(0, 3))
        0: lit.push_back("-");
        1: lit.push_back("+");
        2: if ($urandom_range(0, 3) == 0) lit.push_back("_");
        default: ;
      endcase
      n_exp = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 3);
      for (int i = 0; i < n_exp; i++) begin
        lit.push_back(8'("0") + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 11) == 0) lit.push_back("_");
      end
    end
    // Corrupt a few: random byte, dropped or duplicated character
    if ($urandom_range(0, 9) == 0) begin
      k = $urandom_range(0, lit.size() - 1);
      case ($urandom_range(0, 2))
        0: lit[k] = 8'($urandom_range(0, 255));
        1: if (lit.size() > 1) lit.delete(k);
        default: lit.insert(k, lit[k]);
      endcase
    end
  endfunction

  lit_row_t dir_rows[] = '{
    '{"0x1p0",            1'b0, 1'b1, 64'h3F80_0000, 1'b0},
    '{"-0x0",             1'b0, 1'b1, 64'h8000_0000, 1'b0},
    '{"+0x0p99999",       1'b0, 1'b1, 64'h0000_0000, 1'b0},
    '{"0x1.8p+3",         1'b0, 1'b1, 64'h4140_0000, 1'b0},
    '{"0x_1_p_1_",        1'b0, 1'b1, 64'h4000_0000, 1'b0},
    '{"0x1p-149",         1'b0, 1'b1, 64'h0000_0001, 1'b0},
    '{"0x1p-150",         1'b0, 1'b1, 64'h0000_0000, 1'b0},
    '{"0x1p128",          1'b0, 1'b1, 64'h0,         1'b1},
    '{"0x",               1'b0, 1'b1, 64'h0,         1'b1},
    '{"0x1p",             1'b0, 1'b1, 64'h0,         1'b1},
    '{"0x1..0",           1'b0, 1'b1, 64'h0,         1'b1},
    '{"0X1",              1'b0, 1'b1, 64'h0,         1'b1},
    '{"0xp1",             1'b0, 1'b1, 64'h0,         1'b1},
    '{"1",                1'b0, 1'b1, 64'h0,         1'b1},
    '{"0x.8p1",           1'b0, 1'b0, 64'h0,         1'b0},
    '{"0xffffff.fp104",   1'b0, 1'b0, 64'h0,         1'b0},
    '{"0x123456789abcdef1p-9999999999", 1'b0, 1'b0, 64'h0, 1'b0},
    '{"0x1p0",            1'b1, 1'b1, 64'h3FF0_0000_0000_0000, 1'b0},
    '{"-0x0.",            1'b1, 1'b1, 64'h8000_0000_0000_0000, 1'b0},
    '{"0x1p1024",         1'b1, 1'b1, 64'h0,         1'b1},
    '{"0x1p-1074",        1'b1, 1'b1, 64'h1,         1'b0},
    '{"0x1p99999999999",  1'b1, 1'b1, 64'h0,         1'b1},
    '{"0x1.fffffffffffff8p1023", 1'b1, 1'b0, 64'h0,  1'b0},
    '{"-0xABCDEF.123456789abcdefP-1000", 1'b1, 1'b0, 64'h0, 1'b0}
  };

  // Receiver: stall on a pattern or at random, compare each word with the oldest expectation
  always @(posedge clk) begin
    ieee_word_t w;
    rx_cycle <= rx_cycle + 1;
    out_ch.ready <= (rx_cycle[9:8] == 2'd0) ? 1'b1 :
                    (rx_cycle[9:8] == 2'd1) ? (rx_cycle[2:0] != 3'd5) :
                    ($urandom_range(0, 2) != 0);
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: float_bits %h parse_error %b",
               out_ch.float_bits, out_ch.parse_error);
        failed = 1'b1;
      end else begin
        w = pending_words.pop_front();
        if (out_ch.float_bits !== w.bits) begin
          $error("float_bits expected %h actual %h", w.bits, out_ch.float_bits);
          failed = 1'b1;
        end
        if (out_ch.parse_error !== w.err) begin
          $error("parse_error expected %b actual %b", w.err, out_ch.parse_error);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("[hex_float_literal_to_ieee_bits] ERROR");
    $finish;
  end

  initial begin
    bit [7:0]   lit[$];
    ieee_word_t w;
    in_ch.valid = 1'b0;
    in_ch.text_char = 8'h00;
    in_ch.last_char = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.double_precision = 1'b0;
    fmt_dbl = 1'b0;
    clear_scan();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows; typed-in results are checked against the predictor too
    foreach (dir_rows[r]) begin
      if (dir_rows[r].dbl != fmt_dbl || r == 0) set_format(dir_rows[r].dbl);
      lit.delete();
      for (int i = 0; i < dir_rows[r].text.len(); i++) lit.push_back(dir_rows[r].text[i]);
      send_literal(lit);
      if (dir_rows[r].known) begin
        w = last_word;
        if (w.bits !== dir_rows[r].bits) begin
          $error("row %0d float_bits expected %h predicted %h", r, dir_rows[r].bits, w.bits);
          failed = 1'b1;
        end
        if (w.err !== dir_rows[r].err) begin
          $error("row %0d parse_error expected %b predicted %b", r, dir_rows[r].err, w.err);
          failed = 1'b1;
        end
      end
    end

    // Random literals, switching format between phases
    while (sent_chars < 1050) begin
      if (rows_sent % 40 == 0) set_format($urandom_range(0, 1));
      make_literal(lit);
      send_literal(lit);
      rows_sent++;
    end
    in_ch.valid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (!failed) begin
      $display("[hex_float_literal_to_ieee_bits] OK");
    end else begin
      $display("[hex_float_literal_to_ieee_bits] ERROR");
    end
    $finish;
  end

endmodule

// File: hex_float_literal_to_ieee_bits.f
hw/rtl/hflt_pkg.sv
hw/rtl/hflt_intf.sv
hw/rtl/hflt_scan.sv
hw/rtl/hflt_round.sv
hw/rtl/hex_float_literal_to_ieee_bits.sv
bench/tb_hex_float_literal_to_ieee_bits.sv
